// ----- rtl/core/fgpr_pkg.sv -----
// Shared types, constants and the 5x7 font ROM of the glyph pixel renderer.
// Used by every module of the renderer; depends on nothing else.
`default_nettype none

package fgpr_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int COL_W         = $clog2(GLYPH_COLUMNS);
  localparam int ROW_W         = $clog2(GLYPH_ROWS);
  localparam int COORD_W       = 10;
  localparam int COLOR_W       = 16;
  localparam int CODE_W        = 8;
  localparam int IDX_W         = 6;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 10'd240;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 10'd135;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Glyph indexes of the special characters.
  localparam logic [IDX_W-1:0] GLYPH_SPACE   = 6'd0;
  localparam logic [IDX_W-1:0] GLYPH_DIGIT0  = 6'd1;
  localparam logic [IDX_W-1:0] GLYPH_LETTERA = 6'd11;
  localparam logic [IDX_W-1:0] IDX_MINUS     = 6'd37;
  localparam logic [IDX_W-1:0] IDX_CROSS     = 6'd38;
  localparam logic [IDX_W-1:0] IDX_TWO_DOTS  = 6'd39;
  localparam logic [IDX_W-1:0] IDX_PERIOD    = 6'd40;
  localparam logic [IDX_W-1:0] GLYPH_UNKNOWN = 6'd41;

  // One glyph: glyph[col][row], column 0 in the lowest bits.
  typedef logic [GLYPH_COLUMNS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COL,
    ST_ROW,
    ST_FLUSH,
    ST_REJECT
  } scan_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color_out;
    logic               rejected;
    logic               last;
  } pixel_result_t;

  // Maps a character byte to its glyph index, folding lower case to upper case.
  function automatic logic [IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    logic [IDX_W-1:0]  idx;
    c = code;
    if (c inside {[8'h61:8'h7A]}) c = c - 8'h20;
    if (c == 8'h20) idx = GLYPH_SPACE;
    else if (c inside {[8'h30:8'h39]}) idx = GLYPH_DIGIT0 + IDX_W'(c - 8'h30);
    else if (c inside {[8'h41:8'h5A]}) idx = GLYPH_LETTERA + IDX_W'(c - 8'h41);
    else if (c == 8'h2D) idx = IDX_MINUS;
    else if (c == 8'h2B) idx = IDX_CROSS;
    else if (c == 8'h3A) idx = IDX_TWO_DOTS;
    else if (c == 8'h2E) idx = IDX_PERIOD;
    else idx = GLYPH_UNKNOWN;
    return idx;
  endfunction

  function automatic glyph_t mk(input logic [6:0] c0, input logic [6:0] c1,
                                input logic [6:0] c2, input logic [6:0] c3,
                                input logic [6:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  function automatic glyph_t font_rom(input logic [IDX_W-1:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = mk(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
      6'd1:  g = mk(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
      6'd2:  g = mk(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
      6'd3:  g = mk(7'h62, 7'h51, 7'h49, 7'h49, 7'h46);
      6'd4:  g = mk(7'h22, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd5:  g = mk(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
      6'd6:  g = mk(7'h2F, 7'h49, 7'h49, 7'h49, 7'h31);
      6'd7:  g = mk(7'h3E, 7'h49, 7'h49, 7'h49, 7'h32);
      6'd8:  g = mk(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      6'd9:  g = mk(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd10: g = mk(7'h26, 7'h49, 7'h49, 7'h49, 7'h3E);
      6'd11: g = mk(7'h7E, 7'h09, 7'h09, 7'h09, 7'h7E);
      6'd12: g = mk(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd13: g = mk(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
      6'd14: g = mk(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
      6'd15: g = mk(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
      6'd16: g = mk(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
      6'd17: g = mk(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
      6'd18: g = mk(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
      6'd19: g = mk(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
      6'd20: g = mk(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
      6'd21: g = mk(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
      6'd22: g = mk(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
      6'd23: g = mk(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
      6'd24: g = mk(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
      6'd25: g = mk(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
      6'd26: g = mk(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
      6'd27: g = mk(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
      6'd28: g = mk(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
      6'd29: g = mk(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
      6'd30: g = mk(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
      6'd31: g = mk(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
      6'd32: g = mk(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
      6'd33: g = mk(7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F);
      6'd34: g = mk(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      6'd35: g = mk(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
      6'd36: g = mk(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
      6'd37: g = mk(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
      6'd38: g = mk(7'h08, 7'h08, 7'h3E, 7'h08, 7'h08);
      6'd39: g = mk(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
      6'd40: g = mk(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
      default: g = mk(7'h7F, 7'h41, 7'h5D, 7'h41, 7'h7F);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fgpr_clip_unit.sv -----
// Shared coordinate unit: adds a glyph offset to an anchor and compares the
// sum against a display limit. Depends on fgpr_pkg.
`default_nettype none

module fgpr_clip_unit (
  input  wire logic [fgpr_pkg::COORD_W-1:0] base,
  input  wire logic [fgpr_pkg::COL_W-1:0]   offset,
  input  wire logic [fgpr_pkg::COORD_W-1:0] limit,
  output logic      [fgpr_pkg::COORD_W-1:0] coord,
  output logic                              clipped
);

  logic [fgpr_pkg::COORD_W:0] sum;

  // The sum is one bit wider so that it never wraps past the limit.
  assign sum     = {1'b0, base} + (fgpr_pkg::COORD_W + 1)'(offset);
  assign coord   = sum[fgpr_pkg::COORD_W-1:0];
  assign clipped = sum >= {1'b0, limit};

endmodule

`default_nettype wire

// ----- rtl/core/fgpr_scanner.sv -----
// Glyph scan sequencer: walks columns and rows of one glyph through the shared
// clip unit and hands lit pixels to the output stage. Depends on fgpr_pkg and
// fgpr_clip_unit.
`default_nettype none

module fgpr_scanner (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [fgpr_pkg::CODE_W-1:0]       char_code,
  input  wire logic [fgpr_pkg::COORD_W-1:0]      anchor_x,
  input  wire logic [fgpr_pkg::COORD_W-1:0]      anchor_y,
  input  wire logic [fgpr_pkg::COLOR_W-1:0]      pixel_color,
  input  wire logic [fgpr_pkg::COORD_W-1:0]      display_width,
  input  wire logic [fgpr_pkg::COORD_W-1:0]      display_height,
  output logic                                   push_valid,
  output fgpr_pkg::pixel_result_t                push_data,
  input  wire logic                              push_ready
);

  fgpr_pkg::scan_state_t state, state_next;
  logic [fgpr_pkg::COL_W-1:0]   col, col_next;
  logic [fgpr_pkg::ROW_W-1:0]   row, row_next;
  fgpr_pkg::glyph_t             glyph, glyph_next;
  logic [fgpr_pkg::COORD_W-1:0] ax, ax_next;
  logic [fgpr_pkg::COORD_W-1:0] ay, ay_next;
  logic [fgpr_pkg::COLOR_W-1:0] color, color_next;
  logic [fgpr_pkg::COORD_W-1:0] px, px_next;
  fgpr_pkg::pixel_result_t      pend, pend_next;
  logic                         pend_valid, pend_valid_next;

  logic [fgpr_pkg::COORD_W-1:0] unit_base;
  logic [fgpr_pkg::COL_W-1:0]   unit_offset;
  logic [fgpr_pkg::COORD_W-1:0] unit_limit;
  logic [fgpr_pkg::COORD_W-1:0] unit_coord;
  logic                         unit_clipped;
  logic                         advance;
  logic                         end_col;

  fgpr_clip_unit u_clip (
    .base    (unit_base),
    .offset  (unit_offset),
    .limit   (unit_limit),
    .coord   (unit_coord),
    .clipped (unit_clipped)
  );

  // Operand selection for the shared unit.
  always_comb begin
    unit_base   = ay;
    unit_offset = '0;
    unit_limit  = display_height;
    if (state == fgpr_pkg::ST_COL) begin
      unit_base   = ax;
      unit_offset = col;
      unit_limit  = display_width;
    end else if (state == fgpr_pkg::ST_ROW) begin
      unit_offset = fgpr_pkg::COL_W'(row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fgpr_pkg::ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
    end
    col   <= col_next;
    row   <= row_next;
    glyph <= glyph_next;
    ax    <= ax_next;
    ay    <= ay_next;
    color <= color_next;
    px    <= px_next;
    pend  <= pend_next;
  end

  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    glyph_next      = glyph;
    ax_next         = ax;
    ay_next         = ay;
    color_next      = color;
    px_next         = px;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    in_ready        = 1'b0;
    push_valid      = 1'b0;
    push_data       = pend;
    advance         = 1'b1;
    end_col         = 1'b0;

    case (state)
      fgpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          glyph_next = fgpr_pkg::font_rom(fgpr_pkg::glyph_index(char_code));
          ax_next    = anchor_x;
          ay_next    = anchor_y;
          color_next = pixel_color;
          state_next = fgpr_pkg::ST_CHECK;
        end
      end
      fgpr_pkg::ST_CHECK: begin
        col_next = '0;
        if (unit_clipped) state_next = fgpr_pkg::ST_REJECT;
        else state_next = fgpr_pkg::ST_COL;
      end
      fgpr_pkg::ST_COL: begin
        if (unit_clipped) begin
          state_next = fgpr_pkg::ST_FLUSH;
        end else begin
          px_next    = unit_coord;
          row_next   = '0;
          state_next = fgpr_pkg::ST_ROW;
        end
      end
      fgpr_pkg::ST_ROW: begin
        if (!unit_clipped && glyph[col][row]) begin
          // A newer lit pixel proves the held one is not the last.
          if (pend_valid) begin
            push_valid     = 1'b1;
            push_data      = pend;
            push_data.last = 1'b0;
            advance        = push_ready;
          end
          if (advance) begin
            pend_next.pixel_x   = px;
            pend_next.pixel_y   = unit_coord;
            pend_next.color_out = color;
            pend_next.rejected  = 1'b0;
            pend_next.last      = 1'b0;
            pend_valid_next     = 1'b1;
          end
        end
        end_col = unit_clipped || (row == fgpr_pkg::ROW_W'(fgpr_pkg::GLYPH_ROWS - 1));
        if (advance) begin
          if (end_col) begin
            if (col == fgpr_pkg::COL_W'(fgpr_pkg::GLYPH_COLUMNS - 1)) begin
              state_next = fgpr_pkg::ST_FLUSH;
            end else begin
              col_next   = col + fgpr_pkg::COL_W'(1);
              state_next = fgpr_pkg::ST_COL;
            end
          end else begin
            row_next = row + fgpr_pkg::ROW_W'(1);
          end
        end
      end
      fgpr_pkg::ST_FLUSH: begin
        if (pend_valid) begin
          push_valid     = 1'b1;
          push_data      = pend;
          push_data.last = 1'b1;
          if (push_ready) begin
            pend_valid_next = 1'b0;
            state_next      = fgpr_pkg::ST_IDLE;
          end
        end else begin
          state_next = fgpr_pkg::ST_IDLE;
        end
      end
      fgpr_pkg::ST_REJECT: begin
        push_valid = 1'b1;
        push_data  = '{pixel_x: '0, pixel_y: '0, color_out: '0, rejected: 1'b1, last: 1'b1};
        if (push_ready) state_next = fgpr_pkg::ST_IDLE;
      end
      default: begin
        state_next = fgpr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/fgpr_out_stage.sv -----
// Output register of the renderer: holds one result until the stream sink
// takes it. Depends on fgpr_pkg.
`default_nettype none

module fgpr_out_stage (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push_valid,
  input  wire fgpr_pkg::pixel_result_t push_data,
  output logic                         push_ready,
  output logic                         out_valid,
  output fgpr_pkg::pixel_result_t      out_data,
  input  wire logic                    out_ready
);

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push_valid;
    end
    if (push_ready && push_valid) begin
      out_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/font_glyph_pixel_renderer_top.sv -----
// Top level of the 5x7 bitmap font glyph pixel renderer.
// Depends on fgpr_pkg, fgpr_clip_unit, fgpr_scanner and fgpr_out_stage.
`default_nettype none

// The renderer takes one character transaction (byte, anchor and RGB565
// color) and emits one pixel transaction for each lit bit of the character's
// 5x7 glyph, scanning column 0 to 4 and, within a column, row 0 to 6. Lower
// case letters render as upper case, and bytes outside the font show a boxed
// unknown glyph. Columns at or beyond display_width end the scan and rows at
// or beyond display_height end their column. An anchor row that is already
// off screen yields a single transaction with tuser (rejected) set and all
// data zero. tlast marks the final pixel of a character; a blank or fully
// clipped glyph yields no output at all. The input side is ready only while
// no character is in progress. A character passes an anchor row check, then
// a column step for each visible column and a row step for each row scanned
// in it, then a flush, and the scan waits while the output stage stalls. The
// scan sequencer sends every coordinate through one shared add and compare
// unit. The width and height registers are written through the cfg port;
// the user must write them only while the block is idle; nothing enforces it.

module font_glyph_pixel_renderer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data,
  // Character input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // char_code [7:0], anchor_x [17:8], anchor_y [27:18], pixel_color [43:28]
  input  wire logic [47:0] s_axis_tdata,
  // Pixel output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_x [9:0], pixel_y [19:10], color_out [35:20]
  output logic [39:0]      m_axis_tdata,
  // rejected [0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic [fgpr_pkg::COORD_W-1:0] display_width;
  logic [fgpr_pkg::COORD_W-1:0] display_height;

  logic                    push_valid;
  logic                    push_ready;
  fgpr_pkg::pixel_result_t push_data;
  fgpr_pkg::pixel_result_t out_data;

  // Display size registers, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= fgpr_pkg::WIDTH_RESET;
      display_height <= fgpr_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fgpr_pkg::REG_WIDTH:  display_width  <= cfg_data;
        fgpr_pkg::REG_HEIGHT: display_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The sequencer walks the glyph and holds back one pixel so that it knows
  // which pixel is last when the scan ends.
  fgpr_scanner u_scanner (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .char_code      (s_axis_tdata[7:0]),
    .anchor_x       (s_axis_tdata[17:8]),
    .anchor_y       (s_axis_tdata[27:18]),
    .pixel_color    (s_axis_tdata[43:28]),
    .display_width  (display_width),
    .display_height (display_height),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .push_ready     (push_ready)
  );

  // The output register decouples the scan from a stalled sink.
  fgpr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (m_axis_tvalid),
    .out_data   (out_data),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, out_data.color_out, out_data.pixel_y, out_data.pixel_x};
  assign m_axis_tuser = out_data.rejected;
  assign m_axis_tlast = out_data.last;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 5x7 glyph pixel renderer top level.
// Depends on fgpr_pkg and font_glyph_pixel_renderer_top, and through it on its submodules.
`timescale 1ns / 1ps

module tb_top;

  // Idle cycles without any transaction before the run is declared hung. The
  // slowest legal character plus output stalls and the longest deliberate
  // receiver hold-off, HOLD_CYCLES, both stay well within this limit.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles allowed after the last expected pixel for a character that lights
  // nothing to finish its scan: setup plus a full scan, with margin.
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_COUNT    = 8;

  // How a directed row is checked: by the predictor, or by a result that is
  // obvious on sight (one rejection, or no pixels at all).
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_REJECT,
    ROW_BLANK
  } row_kind_t;

  typedef struct {
    logic [fgpr_pkg::CODE_W-1:0]  code;
    logic [fgpr_pkg::COORD_W-1:0] ax;
    logic [fgpr_pkg::COORD_W-1:0] ay;
    logic [fgpr_pkg::COLOR_W-1:0] color;
    row_kind_t                    kind;
  } char_row_t;

  // Font columns as bytes, column 0 first; bit n of a byte is glyph row n.
  typedef logic [0:fgpr_pkg::GLYPH_COLUMNS-1][7:0] glyph_cols_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = fgpr_pkg::REG_WIDTH;
  logic [9:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  font_glyph_pixel_renderer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the display size, updated whenever the registers are written.
  logic [fgpr_pkg::COORD_W-1:0] disp_width  = fgpr_pkg::WIDTH_RESET;
  logic [fgpr_pkg::COORD_W-1:0] disp_height = fgpr_pkg::HEIGHT_RESET;

  // Pixels the block still owes us, oldest first.
  fgpr_pkg::pixel_result_t pixel_queue[$];

  int failures      = 0;
  int chars_sent    = 0;
  int pixels_seen   = 0;
  int rejects_seen  = 0;
  int configs_done  = 0;

  // Shared with the receiver process: the idle rate of the current phase and
  // the one-shot request for a long hold-off.
  int idle_pct      = 0;
  bit hold_request  = 1'b0;

  string font_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz -+:.";

  // Works out every pixel one character lights under the current display size
  // and appends them to the queue. The last pixel is only known once the scan
  // is over, so each pixel is held back by one until the next one shows up.
  function automatic void predict_pixels(input logic [fgpr_pkg::CODE_W-1:0]  code,
                                         input logic [fgpr_pkg::COORD_W-1:0] ax,
                                         input logic [fgpr_pkg::COORD_W-1:0] ay,
                                         input logic [fgpr_pkg::COLOR_W-1:0] color);
    logic [7:0]              ch;
    glyph_cols_t             cols;
    fgpr_pkg::pixel_result_t held;
    bit                      have_held;
    int unsigned             x;
    int unsigned             y;
    held = '0;
    have_held = 1'b0;
    if (ay >= disp_height) begin
      held.rejected = 1'b1;
      held.last     = 1'b1;
      pixel_queue.push_back(held);
      return;
    end
    ch = code;
    // Fold lower case onto upper case.
    if (ch >= "a" && ch <= "z") ch = ch - ("a" - "A");
    case (ch)
      " ": cols = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      "0": cols = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      "1": cols = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      "2": cols = {8'h62, 8'h51, 8'h49, 8'h49, 8'h46};
      "3": cols = {8'h22, 8'h49, 8'h49, 8'h49, 8'h36};
      "4": cols = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      "5": cols = {8'h2F, 8'h49, 8'h49, 8'h49, 8'h31};
      "6": cols = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h32};
      "7": cols = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      "8": cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      "9": cols = {8'h26, 8'h49, 8'h49, 8'h49, 8'h3E};
      "A": cols = {8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E};
      "B": cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      "C": cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      "D": cols = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      "E": cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      "F": cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      "G": cols = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      "H": cols = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      "I": cols = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      "J": cols = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      "K": cols = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      "L": cols = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      "M": cols = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      "N": cols = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      "O": cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      "P": cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      "Q": cols = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      "R": cols = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      "S": cols = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      "T": cols = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      "U": cols = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      "V": cols = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      "W": cols = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      "X": cols = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      "Y": cols = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      "Z": cols = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      "-": cols = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      "+": cols = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
      ":": cols = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      ".": cols = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      // Anything outside the font shows the boxed unknown glyph.
      default: cols = {8'h7F, 8'h41, 8'h5D, 8'h41, 8'h7F};
    endcase
    for (int col = 0; col < fgpr_pkg::GLYPH_COLUMNS; col++) begin
      // Sums are formed in 32 bits, so an anchor near 1023 never wraps.
      x = ax + col;
      if (x >= disp_width) break;
      for (int r = 0; r < fgpr_pkg::GLYPH_ROWS; r++) begin
        y = ay + r;
        if (y >= disp_height) break;
        if (cols[col][r]) begin
          if (have_held) pixel_queue.push_back(held);
          held.pixel_x   = x[fgpr_pkg::COORD_W-1:0];
          held.pixel_y   = y[fgpr_pkg::COORD_W-1:0];
          held.color_out = color;
          held.rejected  = 1'b0;
          held.last      = 1'b0;
          have_held      = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pixel_queue.push_back(held);
    end
  endfunction

  function automatic char_row_t char_row(input logic [fgpr_pkg::CODE_W-1:0]  code,
                                         input int                           ax,
                                         input int                           ay,
                                         input logic [fgpr_pkg::COLOR_W-1:0] color,
                                         input row_kind_t                    kind);
    char_row_t r;
    r.code  = code;
    r.ax    = ax[fgpr_pkg::COORD_W-1:0];
    r.ay    = ay[fgpr_pkg::COORD_W-1:0];
    r.color = color;
    r.kind  = kind;
    return r;
  endfunction

  // Random coordinate against one display limit: mostly on screen, often
  // straddling the edge so that clipping and rejection are hit, now and then
  // anywhere in the 10-bit range.
  function automatic int pick_coord(input logic [fgpr_pkg::COORD_W-1:0] limit);
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 99);
    if (limit == 0 || r < 15) return $urandom_range(0, 1023);
    if (r < 40) begin
      lo = (limit > 7) ? limit - 7 : 0;
      hi = (limit < 1023) ? limit + 1 : 1023;
      return $urandom_range(lo, hi);
    end
    return $urandom_range(0, limit - 1);
  endfunction

  // Presents one character starting at a falling edge and holds it until the
  // block takes it. The expectation is recorded at the accepting edge, well
  // ahead of the first pixel. Returns at the next falling edge with tvalid
  // still high, so a back-to-back character does not drop it.
  task automatic send_char(input char_row_t it);
    fgpr_pkg::pixel_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.color, it.ay, it.ax, it.code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
    case (it.kind)
      ROW_REJECT: begin
        r = '0;
        r.rejected = 1'b1;
        r.last     = 1'b1;
        pixel_queue.push_back(r);
      end
      ROW_BLANK: ;
      default: predict_pixels(it.code, it.ax, it.ay, it.color);
    endcase
    @(negedge clk);
  endtask

  task automatic pause_source(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits for every owed pixel, then for a possible blank character that is
  // still being scanned, so that the block is idle afterwards.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both size registers on consecutive edges; only called while idle.
  task automatic write_display(input logic [fgpr_pkg::COORD_W-1:0] w,
                               input logic [fgpr_pkg::COORD_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= fgpr_pkg::REG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= fgpr_pkg::REG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    disp_width  = w;
    disp_height = h;
    configs_done++;
  endtask

  // Receiver: random bursts of back-pressure at the phase's rate, plus one long
  // hold-off on request so that the block backs up and stalls its input.
  int hold_left  = 0;
  int stall_left = 0;
  bit hold_taken = 1'b0;

  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output checker. Signals are read in the active region of the rising edge,
  // before the block's own updates of that edge land.
  fgpr_pkg::pixel_result_t seen_px;
  fgpr_pkg::pixel_result_t want_px;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_px.pixel_x   = m_axis_tdata[9:0];
      seen_px.pixel_y   = m_axis_tdata[19:10];
      seen_px.color_out = m_axis_tdata[35:20];
      seen_px.rejected  = m_axis_tuser;
      seen_px.last      = m_axis_tlast;
      if (seen_px.rejected) rejects_seen++;
      else pixels_seen++;
      if (pixel_queue.size() == 0) begin
        failures++;
        $display("%0t: unexpected pixel transaction x=%0d y=%0d color=%h rejected=%b last=%b",
                 $time, seen_px.pixel_x, seen_px.pixel_y, seen_px.color_out,
                 seen_px.rejected, seen_px.last);
      end else begin
        want_px = pixel_queue.pop_front();
        if (seen_px !== want_px) begin
          failures++;
          $display("%0t: pixel mismatch: expected x=%0d y=%0d color=%h rejected=%b last=%b",
                   $time, want_px.pixel_x, want_px.pixel_y, want_px.color_out,
                   want_px.rejected, want_px.last);
          $display("%0t:                 actual   x=%0d y=%0d color=%h rejected=%b last=%b",
                   $time, seen_px.pixel_x, seen_px.pixel_y, seen_px.color_out,
                   seen_px.rejected, seen_px.last);
        end
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d pixels still owed",
                 $time, WATCHDOG_LIMIT, pixel_queue.size());
        $display("font_glyph_pixel_renderer_top regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    char_row_t   directed_rows[$];
    char_row_t   it;
    logic [9:0]  w;
    logic [9:0]  h;
    int          item_count;

    // Directed table, run with the reset size of 240 x 135. Rejections and
    // blank results are typed in; everything else goes through the predictor.
    directed_rows.push_back(char_row("A", 0, 0, 16'hFFFF, ROW_PREDICT));
    directed_rows.push_back(char_row("a", 10, 10, 16'h1234, ROW_PREDICT));
    directed_rows.push_back(char_row("z", 20, 20, 16'h0000, ROW_PREDICT));
    directed_rows.push_back(char_row("Z", 30, 20, 16'hF800, ROW_PREDICT));
    directed_rows.push_back(char_row("0", 40, 30, 16'h07E0, ROW_PREDICT));
    directed_rows.push_back(char_row("9", 50, 30, 16'h001F, ROW_PREDICT));
    directed_rows.push_back(char_row("-", 60, 40, 16'hAAAA, ROW_PREDICT));
    directed_rows.push_back(char_row("+", 70, 40, 16'h5555, ROW_PREDICT));
    directed_rows.push_back(char_row(":", 80, 50, 16'h8001, ROW_PREDICT));
    directed_rows.push_back(char_row(".", 90, 50, 16'h7FFE, ROW_PREDICT));
    // A space lights nothing.
    directed_rows.push_back(char_row(" ", 0, 0, 16'hFFFF, ROW_BLANK));
    // Bytes just outside the upper and lower case letter ranges, and the byte extremes, all fall
    // back to the unknown box.
    directed_rows.push_back(char_row(8'h00, 100, 60, 16'h1111, ROW_PREDICT));
    directed_rows.push_back(char_row(8'hFF, 110, 60, 16'h2222, ROW_PREDICT));
    directed_rows.push_back(char_row(8'h60, 120, 60, 16'h3333, ROW_PREDICT));
    directed_rows.push_back(char_row(8'h7B, 130, 60, 16'h4444, ROW_PREDICT));
    directed_rows.push_back(char_row(8'h40, 140, 60, 16'h5555, ROW_PREDICT));
    directed_rows.push_back(char_row(8'h5B, 150, 60, 16'h6666, ROW_PREDICT));
    // Anchor row on or past the bottom edge: one rejection, data all zero.
    directed_rows.push_back(char_row("H", 0, 135, 16'hFFFF, ROW_REJECT));
    directed_rows.push_back(char_row(8'hFF, 1023, 1023, 16'hFFFF, ROW_REJECT));
    // Anchor column past the right edge clips every column.
    directed_rows.push_back(char_row("8", 1023, 0, 16'hFFFF, ROW_BLANK));
    directed_rows.push_back(char_row("H", 240, 10, 16'hFFFF, ROW_BLANK));
    // Partial clipping on the right, at the bottom, and on both.
    directed_rows.push_back(char_row("M", 238, 40, 16'hC0DE, ROW_PREDICT));
    directed_rows.push_back(char_row("B", 100, 134, 16'hBEEF, ROW_PREDICT));
    directed_rows.push_back(char_row("8", 239, 130, 16'hFACE, ROW_PREDICT));
    directed_rows.push_back(char_row("8", 0, 0, 16'h0000, ROW_PREDICT));

    // Single reset at the start of the run.
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 25;
    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 99) < idle_pct) pause_source($urandom_range(1, 6));
      send_char(directed_rows[i]);
    end
    drain_results();

    // Random phases, each under its own display size. The first few pin the
    // register extremes, including a zero size that clips or rejects all.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin w = 10'd1023; h = 10'd1023; end
        1: begin w = 10'd1;    h = 10'd1;    end
        2: begin w = 10'd0;    h = 10'd135;  end
        3: begin w = 10'd240;  h = 10'd0;    end
        5: begin
          w = 10'($urandom_range(1, 12));
          h = 10'($urandom_range(1, 12));
        end
        7: begin w = fgpr_pkg::WIDTH_RESET; h = fgpr_pkg::HEIGHT_RESET; end
        default: begin
          w = 10'($urandom_range(1, 1023));
          h = 10'($urandom_range(1, 1023));
        end
      endcase
      write_display(w, h);
      case (phase)
        1: item_count = 25;
        2, 3: item_count = 10;
        default: item_count = 55;
      endcase
      // No idling in the closing phase; the rest cycle through three rates.
      idle_pct = (phase == PHASE_COUNT - 1) ? 0 : (phase % 3) * 25;

      for (int n = 0; n < item_count; n++) begin
        // Back up the whole pipe once while characters keep coming.
        if (phase == 4 && n == 10) hold_request = 1'b1;
        // And once let the block run completely dry mid-phase.
        if (phase == 6 && n == 25) drain_results();
        if ($urandom_range(0, 99) < 70)
          it.code = font_chars[$urandom_range(0, font_chars.len() - 1)];
        else
          it.code = fgpr_pkg::CODE_W'($urandom_range(0, 255));
        it.ax    = fgpr_pkg::COORD_W'(pick_coord(disp_width));
        it.ay    = fgpr_pkg::COORD_W'(pick_coord(disp_height));
        it.color = fgpr_pkg::COLOR_W'($urandom_range(0, 65535));
        it.kind  = ROW_PREDICT;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
          pause_source($urandom_range(1, 6));
        send_char(it);
      end
      drain_results();
    end

    $display("Rendered %0d characters under %0d display sizes: %0d pixels, %0d rejections.",
             chars_sent, configs_done + 1, pixels_seen, rejects_seen);
    $display("Included zero and full-range sizes, a long output hold-off and a full drain.");
    if (failures == 0 && pixel_queue.size() == 0) begin
      $display("font_glyph_pixel_renderer_top regression: pass");
    end else begin
      $display("font_glyph_pixel_renderer_top regression: fail");
    end
    $finish;
  end

endmodule
